// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPL(lbl, clk_sig, rst_n_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk_sig, rst_n_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: design/hdlc_dfr_pkg.sv
// Types, constants and the CRC byte fold for the HDLC deframer.
package hdlc_dfr_pkg;

	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [7:0]  ESC_BYTE  = 8'h7D;
	localparam logic [7:0]  ESC_XOR   = 8'h20;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'h8408;
	localparam logic [1:0]  SEEN_SAT  = 2'd3;
	localparam logic [1:0]  SEEN_EMIT = 2'd2;

	typedef enum logic [1:0] {
		ST_GOOD  = 2'd0,
		ST_BAD   = 2'd1,
		ST_SHORT = 2'd2
	} frame_status_t;

	typedef struct packed {
		logic          valid;
		logic [7:0]    payload;
		logic          eof;
		frame_status_t status;
	} result_t;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: design/hdlc_dfr_input_stage.sv
// Input register stage: captures one received byte per transaction.
module hdlc_dfr_input_stage
	import hdlc_dfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

// File: design/hdlc_dfr_frame_logic.sv
// Unstuffing, delay line, CRC accumulation and frame verdict.
module hdlc_dfr_frame_logic
	import hdlc_dfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] byte_s1,
	output result_t    res
);

	logic        esc_q;
	logic [15:0] crc_q;
	logic [7:0]  d0_q;
	logic [7:0]  d1_q;
	logic [1:0]  seen_q;

	logic        is_flag;
	logic        is_esc;
	logic [7:0]  b_un;
	logic        emit;
	logic [15:0] crc_next;

	assign is_flag  = (byte_s1 == FLAG_BYTE);
	assign is_esc   = (byte_s1 == ESC_BYTE);
	assign b_un     = esc_q ? (byte_s1 ^ ESC_XOR) : byte_s1;
	assign emit     = (seen_q >= SEEN_EMIT);
	assign crc_next = crc_fold(crc_q, d0_q);

	always_comb begin
		res.valid   = 1'b0;
		res.payload = 8'h00;
		res.eof     = 1'b0;
		res.status  = ST_GOOD;
		if (is_flag) begin
			res.valid = (seen_q != 2'd0);
			res.eof   = 1'b1;
			if (seen_q != SEEN_SAT) begin
				res.status = ST_SHORT;
			end else if ({d1_q, d0_q} == ~crc_q) begin
				res.status = ST_GOOD;
			end else begin
				res.status = ST_BAD;
			end
		end else if (!is_esc && emit) begin
			res.valid   = 1'b1;
			res.payload = d0_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= 1'b0;
			crc_q  <= CRC_INIT;
			d0_q   <= 8'h00;
			d1_q   <= 8'h00;
			seen_q <= 2'd0;
		end else if (fire) begin
			if (is_flag) begin
				esc_q  <= 1'b0;
				crc_q  <= CRC_INIT;
				d0_q   <= 8'h00;
				d1_q   <= 8'h00;
				seen_q <= 2'd0;
			end else if (is_esc) begin
				esc_q <= 1'b1;
			end else begin
				esc_q <= 1'b0;
				if (emit) begin
					crc_q <= crc_next;
				end
				d0_q <= d1_q;
				d1_q <= b_un;
				if (seen_q != SEEN_SAT) begin
					seen_q <= seen_q + 2'd1;
				end
			end
		end
	end

endmodule

// File: design/hdlc_dfr_output_stage.sv
// Result register: holds one result until the downstream transaction completes.
module hdlc_dfr_output_stage
	import hdlc_dfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s1,
	input  result_t    res,
	output logic       advance,
	output logic       fire,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] payload_byte,
	output logic       end_of_frame,
	output logic [1:0] frame_status
);

	logic          valid_q;
	logic [7:0]    payload_q;
	logic          eof_q;
	frame_status_t status_q;

	assign advance = !valid_q || !out_stall;
	assign fire    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= fire && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			payload_q <= res.payload;
			eof_q     <= res.eof;
			status_q  <= res.status;
		end
	end

	assign out_valid    = valid_q;
	assign payload_byte = payload_q;
	assign end_of_frame = eof_q;
	assign frame_status = status_q;

endmodule

// File: design/hdlc_deframer_crc16_check_core.sv
// Top level of the HDLC receive deframer with CRC-16/X.25 check.
// Accepts one raw byte per cycle, with no gaps while the output is not stalled;
// a byte's result reaches the output through the input register, then the result
// register, and the CRC fold of a whole byte is done combinationally in one update
// of the CRC register. An output stall holds the result register and, once it is
// full, stalls the input. Flag 0x7E ends a frame, 0x7D escapes the next byte.
// Payload bytes stream out two bytes behind the input, the trailing CRC is never
// emitted, and each non-empty frame closes with one end_of_frame result whose
// frame_status says good, bad CRC or too short; drop the frame's payload unless it
// ends good.
module hdlc_deframer_crc16_check_core
	import hdlc_dfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] payload_byte,
	output logic       end_of_frame,
	output logic [1:0] frame_status
);

	logic       advance;
	logic       fire;
	logic       valid_s1;
	logic [7:0] byte_s1;
	result_t    res;

	hdlc_dfr_input_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	hdlc_dfr_frame_logic u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	hdlc_dfr_output_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.res          (res),
		.advance      (advance),
		.fire         (fire),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.end_of_frame (end_of_frame),
		.frame_status (frame_status)
	);

endmodule

// File: design/hdlc_dfr_checker.sv
// Port-level checker for the HDLC deframer and its bind to the top level.
`include "assert_macros.svh"

module hdlc_dfr_checker
	import hdlc_dfr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] rx_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] payload_byte,
	input logic       end_of_frame,
	input logic [1:0] frame_status
);

	`CHK_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid && $stable(rx_byte))
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(payload_byte))
	`CHK_IMPL(a_eof_zero_payload, clk, arst_n, out_valid && end_of_frame, payload_byte == 8'h00)
	`CHK_IMPL(a_data_status_zero, clk, arst_n, out_valid && !end_of_frame, frame_status == ST_GOOD)
	`CHK_IMPL(a_status_legal, clk, arst_n, out_valid, frame_status <= 2'(ST_SHORT))

endmodule

bind hdlc_deframer_crc16_check_core hdlc_dfr_checker u_chk (.*);

// File: dv/hdlc_deframer_crc16_check_core_tb.sv
// Self-checking testbench for the HDLC receive deframer with CRC-16/X.25 check.
module hdlc_deframer_crc16_check_core_tb
	import hdlc_dfr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic [7:0]    data;
		logic          last;
		frame_status_t verdict;
	} rx_result_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] payload_byte;
	logic       end_of_frame;
	logic [1:0] frame_status;

	// deframer state as predicted
	logic       esc_armed;
	logic [15:0] crc_acc;
	logic [7:0] dly [2];
	logic [1:0] seen_cnt;

	rx_result_t results_due[$];
	rx_result_t head;
	int         fail_count;
	int         bytes_sent;
	int         hold_request;
	bit         calm;

	hdlc_deframer_crc16_check_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.end_of_frame (end_of_frame),
		.frame_status (frame_status)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [15:0] fcs_fold(input logic [15:0] acc, input logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = acc[0] ^ b[i];
			acc = acc >> 1;
			if (fb) begin
				acc = acc ^ CRC_POLY;
			end
		end
		return acc;
	endfunction

	function automatic byte_q_t add_fcs(input byte_q_t body);
		logic [15:0] acc;
		acc = CRC_INIT;
		foreach (body[i]) begin
			acc = fcs_fold(acc, body[i]);
		end
		acc = ~acc;
		body.push_back(acc[7:0]);
		body.push_back(acc[15:8]);
		return body;
	endfunction

	function automatic logic [7:0] pick_content();
		logic [7:0] specials [6];
		specials = '{FLAG_BYTE, ESC_BYTE, 8'h5E, 8'h5D, 8'h00, 8'hFF};
		if ($urandom_range(0, 3) == 0) begin
			return specials[$urandom_range(0, 5)];
		end
		return 8'($urandom);
	endfunction

	function automatic byte_q_t build_body(input int n, input bit with_fcs);
		byte_q_t body;
		for (int i = 0; i < n; i++) begin
			body.push_back(pick_content());
		end
		if (with_fcs) begin
			body = add_fcs(body);
		end
		return body;
	endfunction

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(15, 40);
	endfunction

	task automatic note_mismatch(input string what, input rx_result_t want);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t mismatch, %s: expected %02h/%0b/%0d, got %02h/%0b/%0d",
				$realtime, what, want.data, want.last, want.verdict,
				payload_byte, end_of_frame, frame_status);
		end
	endtask

	task automatic track_byte(input logic [7:0] raw);
		logic [7:0] b;
		rx_result_t r;
		b = raw;
		if (raw == FLAG_BYTE) begin
			if (seen_cnt != 2'd0) begin
				r.data = 8'h00;
				r.last = 1'b1;
				if (seen_cnt < SEEN_SAT) begin
					r.verdict = ST_SHORT;
				end else begin
					r.verdict = ({dly[1], dly[0]} == ~crc_acc) ? ST_GOOD : ST_BAD;
				end
				results_due.push_back(r);
			end
			esc_armed = 1'b0;
			crc_acc = CRC_INIT;
			dly[0] = 8'h00;
			dly[1] = 8'h00;
			seen_cnt = 2'd0;
		end else if (raw == ESC_BYTE) begin
			esc_armed = 1'b1;
		end else begin
			if (esc_armed) begin
				b = raw ^ ESC_XOR;
				esc_armed = 1'b0;
			end
			if (seen_cnt >= SEEN_EMIT) begin
				crc_acc = fcs_fold(crc_acc, dly[0]);
				r.data = dly[0];
				r.last = 1'b0;
				r.verdict = ST_GOOD;
				results_due.push_back(r);
			end
			dly[0] = dly[1];
			dly[1] = b;
			if (seen_cnt != SEEN_SAT) begin
				seen_cnt = seen_cnt + 2'd1;
			end
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = calm ? 0 : pick_idle();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		track_byte(b);
		if (b != ESC_BYTE) begin
			bytes_sent++;
		end
	endtask

	task automatic send_seq(input byte_q_t seq);
		foreach (seq[i]) begin
			send_byte(seq[i]);
		end
	endtask

	// stuff flag and escape bytes, sometimes escape others or re-arm, then close
	task automatic send_frame(input byte_q_t body);
		foreach (body[i]) begin
			if (body[i] == FLAG_BYTE || body[i] == ESC_BYTE || $urandom_range(0, 19) == 0) begin
				if ($urandom_range(0, 29) == 0) begin
					send_byte(ESC_BYTE);
				end
				send_byte(ESC_BYTE);
				send_byte(body[i] ^ ESC_XOR);
			end else begin
				send_byte(body[i]);
			end
		end
		send_byte(FLAG_BYTE);
	endtask

	task automatic test_field_extremes();
		send_byte(FLAG_BYTE);
		send_frame(add_fcs('{8'h00, 8'hFF, FLAG_BYTE, ESC_BYTE}));
	endtask

	task automatic test_frame_cases();
		send_seq('{FLAG_BYTE, FLAG_BYTE});
		send_seq('{ESC_BYTE, FLAG_BYTE});
		send_seq('{8'h41, FLAG_BYTE});
		send_seq('{ESC_BYTE, 8'h5E, 8'h42, FLAG_BYTE});
		send_seq('{ESC_BYTE, ESC_BYTE, 8'h21, 8'h02, 8'h03, FLAG_BYTE});
	endtask

	task automatic test_random_frames(input int target);
		byte_q_t body;
		int r;
		int idx;
		int frames;
		frames = 0;
		while (bytes_sent < target) begin
			if (frames % 8 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			frames++;
			r = $urandom_range(0, 99);
			if (r < 8) begin
				body = build_body($urandom_range(1, 2), 1'b0);
			end else if (r < 95) begin
				body = build_body($urandom_range(1, 14), 1'b1);
			end else begin
				body = build_body($urandom_range(30, 60), 1'b1);
			end
			if (r >= 8 && $urandom_range(0, 4) == 0) begin
				idx = $urandom_range(0, body.size() - 1);
				body[idx] = body[idx] ^ (8'h01 << $urandom_range(0, 7));
			end
			if ($urandom_range(0, 29) == 0) begin
				body.push_back(ESC_BYTE);
			end
			send_frame(body);
			if ($urandom_range(0, 19) == 0) begin
				send_byte(FLAG_BYTE);
			end
		end
		calm = 1'b0;
	endtask

	task automatic test_random_noise(input int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				send_byte(FLAG_BYTE);
			end else if (r == 1) begin
				send_byte(ESC_BYTE);
			end else begin
				send_byte(8'($urandom));
			end
		end
		send_byte(FLAG_BYTE);
	endtask

	task automatic test_backpressure();
		calm = 1'b1;
		hold_request = 80;
		for (int i = 0; i < 4; i++) begin
			send_frame(build_body($urandom_range(10, 14), 1'b1));
		end
		calm = 1'b0;
	endtask

	// receiver: random stalls, long hold-off on request
	initial begin : sink
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (!calm) begin
					stall_left = pick_idle();
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				head.data = 8'h00;
				head.last = 1'b0;
				head.verdict = ST_GOOD;
				note_mismatch("transaction with nothing pending", head);
			end else begin
				head = results_due.pop_front();
				if (payload_byte !== head.data || end_of_frame !== head.last ||
						frame_status !== head.verdict) begin
					note_mismatch("field differs", head);
				end
			end
		end
	end

	initial begin
		fail_count = 0;
		bytes_sent = 0;
		hold_request = 0;
		calm = 1'b0;
		esc_armed = 1'b0;
		crc_acc = CRC_INIT;
		dly[0] = 8'h00;
		dly[1] = 8'h00;
		seen_cnt = 2'd0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		rx_byte <= 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_frame_cases();
		test_random_frames(bytes_sent + 1450);
		test_backpressure();
		test_random_noise(400);
		in_valid <= 1'b0;

		while (results_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (results_due.size() != 0) begin
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/hdlc_dfr_pkg.sv
design/hdlc_dfr_input_stage.sv
design/hdlc_dfr_frame_logic.sv
design/hdlc_dfr_output_stage.sv
design/hdlc_deframer_crc16_check_core.sv
design/hdlc_dfr_checker.sv
dv/hdlc_deframer_crc16_check_core_tb.sv
